// ----- src/fixed_partition_allocator_top_macros.svh -----
// Assertion macros shared by the fixed partition allocator RTL.
`ifndef FIXED_PARTITION_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_PARTITION_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is low.
`define FPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FPA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FPA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- src/fpa_pkg.sv -----
// Package with types, constants and helper functions of the partition allocator.
`default_nettype none

package fpa_pkg;

    localparam int MEMORY_BYTES_DEF = 1024;
    localparam int MAX_PARTS        = 16;
    localparam int IDX_W            = 4;
    localparam int ADDR_W           = 9;
    localparam int SIZE_W           = 10;
    localparam int REQ_W            = 11;
    localparam int ID_W             = 8;
    localparam int POW_W            = 17;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ID_W-1:0]   proc_id;
        logic [REQ_W-1:0]  req_size;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  part_index;
        logic [ADDR_W-1:0] start_addr;
        logic [SIZE_W-1:0] part_size;
    } rsp_t;

    // Number of partitions 2^i that fit below the memory size, capped.
    function automatic int part_count(input int mem_bytes);
        longint sz;
        int     n;
        sz = 1;
        n  = 0;
        for (int i = 0; i < MAX_PARTS; i++) begin
            if (sz < longint'(mem_bytes)) begin
                n  = n + 1;
                sz = sz * 2;
            end
        end
        return n;
    endfunction

    function automatic logic [POW_W-1:0] part_pow(input logic [IDX_W-1:0] idx);
        return POW_W'(1) << idx;
    endfunction

    function automatic logic [ADDR_W-1:0] part_addr(input logic [IDX_W-1:0] idx);
        logic [POW_W-1:0] pow;
        pow = part_pow(idx) - POW_W'(1);
        return pow[ADDR_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] part_bytes(input logic [IDX_W-1:0] idx);
        logic [POW_W-1:0] pow;
        pow = part_pow(idx);
        return pow[SIZE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/fixed_partition_allocator_top.sv -----
// Top level of the fixed partition allocator: request register, table, result register.
`default_nettype none
`include "fixed_partition_allocator_top_macros.svh"

// Fixed partition allocator. Memory is split into partitions of 2^i bytes
// starting at address 2^i - 1 (ten of them, 1 to 512 bytes, for 1024 bytes
// of memory). An allocate request (action 0) takes the lowest free partition
// at least as large as req_size, which is also the best fit; a free request
// (action 1) releases the lowest allocated partition owned by proc_id. Every
// request yields exactly one result; on failure ok is 0 and all other result
// fields are 0. Throughput is one request per cycle sustained while results
// are drained; a request passes through the request register and then the
// result register. The combinational compare and priority pick of the
// partition table, with its flag update committed as the result registers,
// set that rate. s_ready stays high while the result register is empty or
// being drained, so a request can enter while a result waits.

module fixed_partition_allocator_top #(
    parameter int MEMORY_BYTES = fpa_pkg::MEMORY_BYTES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire fpa_pkg::req_t s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output fpa_pkg::rsp_t      m_payload
);
    import fpa_pkg::*;

    localparam int NUM_PARTS = part_count(MEMORY_BYTES);

    logic  req_valid_reg;
    req_t  req_reg;
    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;
    logic  advance;

    // Move the held request into the result register when that slot frees up.
    assign advance = req_valid_reg && (!rsp_valid_reg || m_ready);
    // Take a new request whenever the request register empties this cycle.
    assign s_ready = !req_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    // Capture payload on acceptance; hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_payload;
        end
    end

    // Table state commits in the same cycle the result is registered.
    fpa_table #(
        .NUM_PARTS(NUM_PARTS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .commit  (advance),
        .rsp     (rsp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_valid_reg <= 1'b0;
        end else if (advance) begin
            rsp_valid_reg <= 1'b1;
        end else if (m_ready) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid   = rsp_valid_reg;
    assign m_payload = rsp_reg;

    `FPA_ASSERT_IMP(a_fail_zero, aclk, aresetn, rsp_valid_reg && !rsp_reg.ok, rsp_reg.part_index == '0 && rsp_reg.start_addr == '0 && rsp_reg.part_size == '0)
    `FPA_ASSERT_NXT(a_req_held, aclk, aresetn, req_valid_reg && !advance, req_valid_reg && $stable(req_reg))
    `FPA_ASSERT_IMP(a_ready_only_when_full, aclk, aresetn, !s_ready, req_valid_reg && rsp_valid_reg && !m_ready)

endmodule

`default_nettype wire

// ----- src/fpa_table.sv -----
// Partition table: allocated flags, owner ids, priority pick and update.
`default_nettype none
`include "fixed_partition_allocator_top_macros.svh"

module fpa_table #(
    parameter int NUM_PARTS = 10
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire fpa_pkg::req_t req,
    input  wire logic         commit,
    output fpa_pkg::rsp_t     rsp
);
    import fpa_pkg::*;

    logic [NUM_PARTS-1:0] alloc_flags_reg;
    logic [NUM_PARTS-1:0] alloc_flags_next;
    logic [ID_W-1:0]      owner_ids_reg [NUM_PARTS];
    logic [NUM_PARTS-1:0] cand;
    logic [NUM_PARTS-1:0] sel;
    logic                 found;
    logic [IDX_W-1:0]     pick_idx;

    // Candidate entries for either request kind.
    always_comb begin
        for (int i = 0; i < NUM_PARTS; i++) begin
            if (req.action == ACT_FREE) begin
                cand[i] = alloc_flags_reg[i] && (owner_ids_reg[i] == req.proc_id);
            end else begin
                cand[i] = !alloc_flags_reg[i] &&
                          ((POW_W'(1) << i) >= {{(POW_W-REQ_W){1'b0}}, req.req_size});
            end
        end
    end

    // Lowest index wins.
    always_comb begin
        found    = 1'b0;
        pick_idx = '0;
        sel      = '0;
        for (int i = 0; i < NUM_PARTS; i++) begin
            if (cand[i] && !found) begin
                found    = 1'b1;
                pick_idx = IDX_W'(i);
                sel[i]   = 1'b1;
            end
        end
    end

    always_comb begin
        rsp.ok         = found;
        rsp.part_index = found ? pick_idx : '0;
        rsp.start_addr = found ? part_addr(pick_idx) : '0;
        rsp.part_size  = found ? part_bytes(pick_idx) : '0;
    end

    always_comb begin
        alloc_flags_next = alloc_flags_reg;
        if (commit) begin
            for (int i = 0; i < NUM_PARTS; i++) begin
                if (sel[i]) begin
                    alloc_flags_next[i] = (req.action == ACT_ALLOC);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_flags_reg <= '0;
        end else begin
            alloc_flags_reg <= alloc_flags_next;
        end
    end

    // Owner ids only matter while allocated, so they need no reset.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_PARTS; i++) begin
            if (commit && sel[i] && req.action == ACT_ALLOC) begin
                owner_ids_reg[i] <= req.proc_id;
            end
        end
    end

    `FPA_ASSERT_NXT(a_alloc_grows, aclk, aresetn, commit && found && req.action == ACT_ALLOC, $countones(alloc_flags_reg) == $past($countones(alloc_flags_reg)) + 1)
    `FPA_ASSERT_NXT(a_free_shrinks, aclk, aresetn, commit && found && req.action == ACT_FREE, $countones(alloc_flags_reg) + 1 == $past($countones(alloc_flags_reg)))
    `FPA_ASSERT_NXT(a_fail_holds, aclk, aresetn, !(commit && found), $stable(alloc_flags_reg))

endmodule

`default_nettype wire
